// File: rtl/core/ppid_pkg.sv
// Shared types and constants for the positional PID controller core.
`timescale 1ns / 1ps

package ppid_pkg;

    // Configuration registers are 16 bits whatever the data width
    localparam int REG_W = 16;
    localparam int CFG_ADDR_W = 3;

    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_GAIN_FRAC_BITS = 8;
    localparam int DEF_SUM_LIMIT = 500;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUT_UPPER = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUT_LOWER = 3'd4;

    // Reset values
    localparam logic signed [REG_W-1:0] RST_GAIN = 16'sd0;
    localparam logic signed [REG_W-1:0] RST_OUT_UPPER = 16'sh7FFF;
    localparam logic signed [REG_W-1:0] RST_OUT_LOWER = 16'sh8000;

    typedef struct packed {
        logic signed [REG_W-1:0] gain_p;
        logic signed [REG_W-1:0] gain_i;
        logic signed [REG_W-1:0] gain_d;
        logic signed [REG_W-1:0] out_upper;
        logic signed [REG_W-1:0] out_lower;
    } t_cfg;

endpackage

// File: rtl/core/ppid_cfg_regs.sv
// Configuration register file: gains and output limits.
`timescale 1ns / 1ps

module ppid_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [ppid_pkg::CFG_ADDR_W-1:0]      i_wr_addr,
    input  logic [ppid_pkg::REG_W-1:0]           i_wr_data,
    output ppid_pkg::t_cfg                       o_cfg
);

    ppid_pkg::t_cfg r_cfg;
    ppid_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_addr)
                ppid_pkg::CFG_GAIN_P:    n_cfg.gain_p    = $signed(i_wr_data);
                ppid_pkg::CFG_GAIN_I:    n_cfg.gain_i    = $signed(i_wr_data);
                ppid_pkg::CFG_GAIN_D:    n_cfg.gain_d    = $signed(i_wr_data);
                ppid_pkg::CFG_OUT_UPPER: n_cfg.out_upper = $signed(i_wr_data);
                ppid_pkg::CFG_OUT_LOWER: n_cfg.out_lower = $signed(i_wr_data);
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p    <= ppid_pkg::RST_GAIN;
            r_cfg.gain_i    <= ppid_pkg::RST_GAIN;
            r_cfg.gain_d    <= ppid_pkg::RST_GAIN;
            r_cfg.out_upper <= ppid_pkg::RST_OUT_UPPER;
            r_cfg.out_lower <= ppid_pkg::RST_OUT_LOWER;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/ppid_datapath.sv
// PID arithmetic with the previous-error and clamped-integral state.
`timescale 1ns / 1ps

module ppid_datapath #(
    parameter int DATA_WIDTH     = ppid_pkg::DEF_DATA_WIDTH,
    parameter int GAIN_FRAC_BITS = ppid_pkg::DEF_GAIN_FRAC_BITS,
    parameter int SUM_LIMIT      = ppid_pkg::DEF_SUM_LIMIT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic signed [DATA_WIDTH-1:0]  i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]  i_measured,
    input  ppid_pkg::t_cfg                i_cfg,
    output logic signed [DATA_WIDTH-1:0]  o_drive
);

    localparam int REG_W   = ppid_pkg::REG_W;
    localparam int ERR_W   = DATA_WIDTH + 1;
    localparam int SUM_W   = $clog2(SUM_LIMIT + 1) + 1;
    localparam int NSUM_W  = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
    localparam int DIFF_W  = DATA_WIDTH + 2;
    localparam int WIDE_W  = (DIFF_W > SUM_W) ? DIFF_W : SUM_W;
    localparam int ACC_W   = REG_W + WIDE_W + 2;
    localparam logic signed [NSUM_W-1:0] LIM_POS = NSUM_W'(SUM_LIMIT);
    localparam logic signed [NSUM_W-1:0] LIM_NEG = -NSUM_W'(SUM_LIMIT);

    logic signed [ERR_W-1:0]        r_last_error;
    logic signed [SUM_W-1:0]        r_error_sum;
    logic signed [ERR_W-1:0]        err;
    logic signed [NSUM_W-1:0]       sum_raw;
    logic signed [NSUM_W-1:0]       sum_clamped;
    logic signed [SUM_W-1:0]        n_error_sum;
    logic signed [DIFF_W-1:0]       diff;
    logic signed [REG_W+ERR_W-1:0]  prod_p;
    logic signed [REG_W+SUM_W-1:0]  prod_i;
    logic signed [REG_W+DIFF_W-1:0] prod_d;
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        scaled;
    logic signed [ACC_W-1:0]        upper_ext;
    logic signed [ACC_W-1:0]        lower_ext;
    logic signed [ACC_W-1:0]        drive;

    always_comb begin
        err = ERR_W'(i_setpoint) - ERR_W'(i_measured);

        // Zero integral gain clears and holds the integral
        if (i_cfg.gain_i != '0) begin
            sum_raw = NSUM_W'(r_error_sum) + NSUM_W'(err);
        end else begin
            sum_raw = '0;
        end
        if (sum_raw > LIM_POS) begin
            sum_clamped = LIM_POS;
        end else if (sum_raw < LIM_NEG) begin
            sum_clamped = LIM_NEG;
        end else begin
            sum_clamped = sum_raw;
        end
        n_error_sum = sum_clamped[SUM_W-1:0];

        diff   = DIFF_W'(err) - DIFF_W'(r_last_error);
        prod_p = $signed(i_cfg.gain_p) * err;
        prod_i = $signed(i_cfg.gain_i) * n_error_sum;
        prod_d = $signed(i_cfg.gain_d) * diff;

        // Sum exactly, then floor-shift the total
        acc    = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
        scaled = acc >>> GAIN_FRAC_BITS;

        upper_ext = ACC_W'($signed(i_cfg.out_upper));
        lower_ext = ACC_W'($signed(i_cfg.out_lower));
        drive = scaled;
        if (drive > upper_ext) begin
            drive = upper_ext;
        end
        // lower limit wins when the limits cross
        if (drive < lower_ext) begin
            drive = lower_ext;
        end
    end

    assign o_drive = drive[DATA_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_error_sum  <= '0;
        end else if (i_adv) begin
            r_last_error <= err;
            r_error_sum  <= n_error_sum;
        end
    end

endmodule

// File: rtl/core/positional_pid_controller_core.sv
// Positional PID controller core: stream ports, sample and result registers.
//
// Usage: write gains and limits on the configuration channel (i_cfg_valid,
// i_cfg_addr, i_cfg_data; o_cfg_ready is always high) while the block is idle.
// Indexes 0..4 are gain_p, gain_i, gain_d, out_upper, out_lower; other
// indexes are ignored. Samples enter on the slave stream, one beat holding
// setpoint and measured; each sample yields one drive beat on the master
// stream, in order.
// Path: the input beat is taken into the sample register, then the PID
// arithmetic result is registered into the result register.
// Throughput: one sample per cycle while tready stays high; the previous-error and
// integral state update in the same cycle the sample moves into the result register.
// Stalls: while the receiver holds tready low the result register holds and
// the sample register still takes one more beat; then tready drops.
// Reset: clears both registers' valid flags, the PID state, the gains to
// zero and the limits to the full 16-bit range.
`timescale 1ns / 1ps

module positional_pid_controller_core #(
    parameter int DATA_WIDTH     = ppid_pkg::DEF_DATA_WIDTH,
    parameter int GAIN_FRAC_BITS = ppid_pkg::DEF_GAIN_FRAC_BITS,
    parameter int SUM_LIMIT      = ppid_pkg::DEF_SUM_LIMIT,
    localparam int IN_TDATA_W    = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ppid_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [ppid_pkg::REG_W-1:0]        i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]             i_s_axis_tdata,  // setpoint, measured
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]            o_m_axis_tdata   // drive_out
);

    ppid_pkg::t_cfg cfg;

    logic                          r_in_vld;
    logic signed [DATA_WIDTH-1:0]  r_setpoint;
    logic signed [DATA_WIDTH-1:0]  r_measured;
    logic                          r_out_vld;
    logic signed [DATA_WIDTH-1:0]  r_drive;
    logic signed [DATA_WIDTH-1:0]  drive;
    logic                          in_take;
    logic                          adv;

    assign o_cfg_ready = 1'b1;

    ppid_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_addr (i_cfg_addr),
        .i_wr_data (i_cfg_data),
        .o_cfg     (cfg)
    );

    // Advance a sample when the result register is free or being emptied
    assign adv             = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || adv;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    ppid_datapath #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SUM_LIMIT      (SUM_LIMIT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_setpoint (r_setpoint),
        .i_measured (r_measured),
        .i_cfg      (cfg),
        .o_drive    (drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers: load on the beat, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_setpoint <= $signed(i_s_axis_tdata[DATA_WIDTH-1:0]);
            r_measured <= $signed(i_s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
        end
        if (adv) begin
            r_drive <= drive;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_TDATA_W'($unsigned(r_drive));

endmodule

// File: tb/sv/testbench.sv
// Self-checking stream testbench for the positional PID controller core.
`timescale 1ns / 1ps

module testbench;
    import ppid_pkg::*;

    localparam int DATA_W    = DEF_DATA_WIDTH;
    localparam int FRAC_BITS = DEF_GAIN_FRAC_BITS;
    localparam int SUM_LIM   = DEF_SUM_LIMIT;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 50;
    localparam int ROWS      = 47;

    // Indexes past the register list; writes there must change nothing
    localparam logic [CFG_ADDR_W-1:0] CFG_NONE_LO = CFG_OUT_LOWER + 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_NONE_HI = '1;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [REG_W-1:0]      value;
        logic [DATA_W-1:0]     setpoint;
        logic [DATA_W-1:0]     measured;
        bit                    typed;
        logic [DATA_W-1:0]     drive;
    } step_row_t;

    // kind, index, value, setpoint, measured, typed, drive
    localparam step_row_t DIRECTED_ROWS [0:ROWS-1] = '{
        // gains out of reset are zero
        '{ROW_SAMPLE, '0, '0, 16'sd32767, 16'sh8000, 1'b1, 16'sd0},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sd32767, 1'b1, 16'sd0},
        // unity proportional gain, then saturation at the full range
        '{ROW_CFG, CFG_GAIN_P, 16'sd256, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd100, 16'sd0, 1'b1, 16'sd100},
        '{ROW_SAMPLE, '0, '0, 16'sd32767, 16'sh8000, 1'b1, 16'sd32767},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sd32767, 1'b1, 16'sh8000},
        // smallest gain: the shift rounds toward minus infinity
        '{ROW_CFG, CFG_GAIN_P, 16'sd1, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd0, 16'sd1, 1'b1, -16'sd1},
        '{ROW_SAMPLE, '0, '0, 16'sd1, 16'sd0, 1'b1, 16'sd0},
        '{ROW_CFG, CFG_GAIN_P, -16'sd256, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd0, 16'sd5, 1'b1, 16'sd5},
        // extreme gains against the widest error
        '{ROW_CFG, CFG_GAIN_P, 16'sd32767, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd32767, 16'sh8000, 1'b1, 16'sd32767},
        '{ROW_CFG, CFG_GAIN_P, 16'sh8000, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd32767, 16'sh8000, 1'b1, 16'sh8000},
        // crossed limits: the lower one wins
        '{ROW_CFG, CFG_OUT_UPPER, -16'sd100, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_OUT_LOWER, 16'sd100, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd1234, -16'sd77, 1'b1, 16'sd100},
        '{ROW_CFG, CFG_GAIN_P, 16'sd256, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_OUT_UPPER, 16'sd1000, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_OUT_LOWER, -16'sd1000, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd5000, 16'sd0, 1'b1, 16'sd1000},
        '{ROW_SAMPLE, '0, '0, -16'sd5000, 16'sd0, 1'b1, -16'sd1000},
        // integral alone: clamp at both ends, then clear and restart
        '{ROW_CFG, CFG_GAIN_P, 16'sd0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_GAIN_I, 16'sd256, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd400, 16'sd0, 1'b1, 16'sd400},
        '{ROW_SAMPLE, '0, '0, 16'sd400, 16'sd0, 1'b1, 16'sd500},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sd32767, 1'b1, -16'sd500},
        '{ROW_CFG, CFG_GAIN_I, 16'sd0, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd7, 16'sd0, 1'b1, 16'sd0},
        '{ROW_CFG, CFG_GAIN_I, 16'sd256, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd3, 16'sd0, 1'b1, 16'sd3},
        // derivative alone
        '{ROW_CFG, CFG_GAIN_I, 16'sd0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_GAIN_D, 16'sd256, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd10, 16'sd0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, -16'sd10, 16'sd0, 1'b0, '0},
        // unused indexes
        '{ROW_CFG, CFG_NONE_LO, 16'h1234, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_NONE_HI, 16'hFFFF, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd50, 16'sd20, 1'b0, '0},
        // every register at an extreme
        '{ROW_CFG, CFG_GAIN_P, 16'sd32767, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_GAIN_I, 16'sd32767, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_GAIN_D, 16'sh8000, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_OUT_UPPER, 16'sd32767, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_OUT_LOWER, 16'sh8000, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd32767, 16'sh8000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sd32767, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd0, 16'sd0, 1'b0, '0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [REG_W-1:0]      i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [2*DATA_W-1:0]   i_s_axis_tdata = '0;   // setpoint, measured
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     o_m_axis_tdata;        // drive_out

    // Controller model: registers and the two state words
    t_cfg                      pid_cfg;
    logic signed [DATA_W:0]    prev_error = '0;
    logic signed [9:0]         error_integral = '0;

    logic [DATA_W-1:0] drive_expected_q[$];
    int                error_count = 0;
    bit                idle_on = 1'b1;
    int                stall_left = 0;
    int                phase;
    int                k;
    logic [2*DATA_W-1:0] pair;

    positional_pid_controller_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        pid_cfg.gain_p    = RST_GAIN;
        pid_cfg.gain_i    = RST_GAIN;
        pid_cfg.gain_d    = RST_GAIN;
        pid_cfg.out_upper = RST_OUT_UPPER;
        pid_cfg.out_lower = RST_OUT_LOWER;
    end

    function automatic void apply_cfg(input logic [CFG_ADDR_W-1:0] addr,
                                      input logic [REG_W-1:0] value);
        case (addr)
            CFG_GAIN_P:    pid_cfg.gain_p = value;
            CFG_GAIN_I:    pid_cfg.gain_i = value;
            CFG_GAIN_D:    pid_cfg.gain_d = value;
            CFG_OUT_UPPER: pid_cfg.out_upper = value;
            CFG_OUT_LOWER: pid_cfg.out_lower = value;
            default: ;
        endcase
    endfunction

    // Advance the controller state by one sample and return the clamped drive
    function automatic logic [DATA_W-1:0] pid_drive(input logic signed [DATA_W-1:0] setpoint,
                                                    input logic signed [DATA_W-1:0] measured);
        logic signed [DATA_W:0] err;
        longint sum_next;
        longint acc;
        longint drv;
        err = setpoint - measured;
        if (pid_cfg.gain_i != '0)
            sum_next = longint'(error_integral) + longint'(err);
        else
            sum_next = 0;
        if (sum_next > SUM_LIM)
            sum_next = SUM_LIM;
        if (sum_next < -SUM_LIM)
            sum_next = -SUM_LIM;
        error_integral = sum_next[9:0];
        acc = longint'($signed(pid_cfg.gain_p)) * longint'(err)
            + longint'($signed(pid_cfg.gain_i)) * longint'(error_integral)
            + longint'($signed(pid_cfg.gain_d)) * (longint'(err) - longint'(prev_error));
        drv = acc >>> FRAC_BITS;
        if (drv > longint'($signed(pid_cfg.out_upper)))
            drv = longint'($signed(pid_cfg.out_upper));
        if (drv < longint'($signed(pid_cfg.out_lower)))
            drv = longint'($signed(pid_cfg.out_lower));
        prev_error = err;
        return drv[DATA_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic wait_drained();
        while (drive_expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Stop the sample stream, let the pipeline empty, then write one register
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [REG_W-1:0] value);
        i_s_axis_tvalid <= 1'b0;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        apply_cfg(addr, value);
    endtask

    task automatic send_sample(input logic [DATA_W-1:0] setpoint, input logic [DATA_W-1:0] measured,
                               input bit typed, input logic [DATA_W-1:0] typed_drive);
        logic [DATA_W-1:0] predicted;
        i_cfg_valid <= 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {measured, setpoint};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        predicted = pid_drive(setpoint, measured);
        drive_expected_q.push_back(typed ? typed_drive : predicted);
    endtask

    function automatic logic [REG_W-1:0] rand_gain();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'sd32767;
            2: return 16'sh8000;
            3: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_extreme();
        case ($urandom_range(0, 4))
            0: return 16'sd32767;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    // Mix of full-range, small and near-equal pairs; returns {measured, setpoint}
    function automatic logic [2*DATA_W-1:0] rand_pair();
        logic [DATA_W-1:0] sp;
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            2: return {rand_extreme(), rand_extreme()};
            3, 4, 5: return {16'(int'($urandom_range(0, 600)) - 300),
                             16'(int'($urandom_range(0, 600)) - 300)};
            default: begin
                sp = 16'($urandom);
                return {16'(int'(sp) + int'($urandom_range(0, 128)) - 64), sp};
            end
        endcase
    endfunction

    task automatic set_limits();
        case ($urandom_range(0, 5))
            0: begin
                cfg_write(CFG_OUT_UPPER, 16'sd32767);
                cfg_write(CFG_OUT_LOWER, 16'sh8000);
            end
            1: begin
                cfg_write(CFG_OUT_UPPER, 16'(int'($urandom_range(0, 3000)) - 3000));
                cfg_write(CFG_OUT_LOWER, 16'($urandom_range(1, 3000)));
            end
            2: begin
                cfg_write(CFG_OUT_UPPER, 16'($urandom));
                cfg_write(CFG_OUT_LOWER, 16'($urandom));
            end
            default: begin
                cfg_write(CFG_OUT_UPPER, 16'($urandom_range(0, 4000)));
                cfg_write(CFG_OUT_LOWER, 16'(-int'($urandom_range(0, 4000))));
            end
        endcase
    endtask

    // Receiver: stall in bursts while idling is on
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left      <= $urandom_range(0, 12);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Compare each drive beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (drive_expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected drive %0d",
                                          $signed(o_m_axis_tdata)));
            end else begin
                if (o_m_axis_tdata !== drive_expected_q[0])
                    report_mismatch($sformatf("drive_out got %0d expected %0d",
                                              $signed(o_m_axis_tdata),
                                              $signed(drive_expected_q[0])));
                void'(drive_expected_q.pop_front());
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < ROWS; k++) begin
            if (DIRECTED_ROWS[k].kind == ROW_CFG)
                cfg_write(DIRECTED_ROWS[k].addr, DIRECTED_ROWS[k].value);
            else
                send_sample(DIRECTED_ROWS[k].setpoint, DIRECTED_ROWS[k].measured,
                            DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].drive);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            // Drop idling altogether in the closing phase
            idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            cfg_write(CFG_GAIN_P, rand_gain());
            cfg_write(CFG_GAIN_I, ($urandom_range(0, 3) == 0) ? '0 : rand_gain());
            cfg_write(CFG_GAIN_D, rand_gain());
            set_limits();
            if ($urandom_range(0, 2) == 0)
                cfg_write(CFG_ADDR_W'(int'(CFG_NONE_LO) + $urandom_range(0, 2)), 16'($urandom));
            for (k = 0; k < PHASE_LEN; k++) begin
                pair = rand_pair();
                send_sample(pair[DATA_W-1:0], pair[2*DATA_W-1:DATA_W], 1'b0, '0);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("[positional_pid_controller_core] OK");
        else
            $display("[positional_pid_controller_core] ERROR");
        $finish;
    end

    initial begin
        #400000;
        $display("[positional_pid_controller_core] ERROR");
        $finish;
    end

endmodule
